### hdl/hcrs_pkg.sv
`default_nettype none
package hcrs_pkg;

    localparam int NUM_SENSORS = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_CONE_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONE_RADIUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN = 3'd6;

    typedef struct packed {
        logic        last_point;
        logic signed [15:0] pz;
        logic signed [15:0] py;
        logic signed [15:0] px;
    } point_t;

    typedef struct packed {
        logic        last_result;
        logic        detected;
        logic signed [15:0] range_value;
        logic [2:0]  sensor_index;
    } result_t;

    // Data handed from cell to cell: the body-frame point and its squared norm.
    typedef struct packed {
        logic        vld;
        logic        last;
        logic signed [19:0] bx;
        logic signed [19:0] by;
        logic [38:0] mag2;
    } cell_bus_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROT,
        ST_CELLS,
        ST_EMIT
    } state_t;

    // Axis components in Q1.16, sensor i at i*60 degrees: (cos a, -sin a).
    function automatic logic signed [17:0] axis_cx(input int i);
        case (i)
            0: axis_cx = 18'sd65536;
            1: axis_cx = 18'sd32768;
            2: axis_cx = -18'sd32768;
            3: axis_cx = -18'sd65536;
            4: axis_cx = -18'sd32768;
            default: axis_cx = 18'sd32768;
        endcase
    endfunction

    function automatic logic signed [17:0] axis_cy(input int i);
        case (i)
            0, 3: axis_cy = 18'sd0;
            1, 2: axis_cy = -18'sd56756;
            default: axis_cy = 18'sd56756;
        endcase
    endfunction

endpackage
`default_nettype wire

### hdl/hcrs_cell.sv
`default_nettype none
module hcrs_cell #(
    parameter int SENSOR = 0
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire hcrs_pkg::cell_bus_t  bus_in,
    output hcrs_pkg::cell_bus_t       bus_out,
    input  wire logic [14:0]          cone_length,
    input  wire logic [14:0]          cone_base_radius,
    input  wire logic signed [15:0]   min_range,
    input  wire logic                 clear,
    output logic                      detected,
    output logic signed [15:0]        range_value
);
    import hcrs_pkg::*;

    localparam logic signed [17:0] CX = axis_cx(SENSOR);
    localparam logic signed [17:0] CY = axis_cy(SENSOR);

    // Stage 1: projection products. Stage 2: pu and range test.
    // Stage 3: cone products. Stage 4: compare and update minimum.
    cell_bus_t s1_reg;
    logic signed [36:0] px_reg, py_reg;
    logic s2_vld_reg;
    logic signed [17:0] pu_reg;
    logic [38:0] mag2_reg;
    logic s3_vld_reg;
    logic signed [17:0] pu3_reg;
    logic in_range_reg, in_range3_reg;
    logic signed [39:0] pv2_reg;
    logic [30:0] a_reg;
    logic [29:0] hh_reg;
    logic s4_vld_reg;
    logic signed [17:0] pu4_reg;
    logic hit_pre_reg, need_cmp_reg;
    logic [68:0] lhs_reg;
    logic [61:0] rhs_reg;
    logic valid_reg, valid_next;
    logic signed [16:0] min_reg, min_next;

    logic signed [36:0] sum;
    logic signed [20:0] pu_full;
    logic signed [18:0] hmp;

    assign sum = px_reg + py_reg;
    assign pu_full = 21'(sum >>> 16);
    assign hmp = $signed({4'b0, cone_length}) - pu_reg;

    always_ff @(posedge aclk) begin
        s1_reg <= bus_in;
        px_reg <= 37'(bus_in.bx * CX);
        py_reg <= 37'(bus_in.by * CY);
        pu_reg <= 18'(pu_full);
        mag2_reg <= s1_reg.mag2;
        in_range_reg <= (pu_full > 21'(min_range)) &&
                        (pu_full <= $signed({6'b0, cone_length}));
        pu3_reg <= pu_reg;
        in_range3_reg <= in_range_reg;
        pv2_reg <= $signed({1'b0, mag2_reg}) - 40'(pu_reg * pu_reg);
        a_reg <= 31'(cone_base_radius * hmp[16:0]);
        hh_reg <= 30'(cone_length * cone_length);
        pu4_reg <= pu3_reg;
        hit_pre_reg <= in_range3_reg && (pv2_reg <= 0);
        need_cmp_reg <= in_range3_reg && (pv2_reg > 0);
        // The wide product is split in two halves to keep the multipliers small.
        lhs_reg <= (69'(pv2_reg[38:19] * hh_reg) << 19) + 69'(pv2_reg[18:0] * hh_reg);
        rhs_reg <= a_reg * a_reg;
        min_reg <= min_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            s2_vld_reg <= s1_reg.vld;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            valid_reg <= valid_next;
        end
    end

    logic hit;
    assign hit = s4_vld_reg &&
                 (hit_pre_reg || (need_cmp_reg && (lhs_reg <= {7'b0, rhs_reg})));

    always_comb begin
        valid_next = valid_reg;
        min_next = min_reg;
        if (clear) begin
            valid_next = 1'b0;
        end else if (hit && (!valid_reg || 17'(pu4_reg) <= min_reg)) begin
            valid_next = 1'b1;
            min_next = 17'(pu4_reg);
        end
    end

    assign bus_out = s1_reg;
    assign detected = valid_reg;
    assign range_value = valid_reg ? min_reg[15:0] : 16'sd0;
endmodule
`default_nettype wire

### hdl/hcrs_rotate.sv
`default_nettype none
module hcrs_rotate (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire hcrs_pkg::point_t    point,
    input  wire logic [47:0]         rot_row0,
    input  wire logic [47:0]         rot_row1,
    input  wire logic [47:0]         rot_row2,
    input  wire logic [47:0]         origin_packed,
    output hcrs_pkg::cell_bus_t      bus_out
);
    import hcrs_pkg::*;

    // One multiplier walks the nine matrix entries; a second one forms the three squares.
    logic [3:0] step_reg;
    logic busy_reg;
    logic last_reg;
    logic signed [16:0] d_reg [3];
    logic signed [35:0] acc_reg;
    logic signed [19:0] b_reg [3];
    logic [38:0] mag_reg;
    logic signed [15:0] coef;
    logic signed [16:0] dsel;
    logic [1:0] row, col;
    logic [1:0] row_reg, col_reg;
    logic [47:0] rsel;
    logic out_vld_reg;
    logic signed [19:0] sq_reg;
    logic [37:0] sqp_reg;

    assign row = row_reg;
    assign col = col_reg;
    always_comb begin
        case (row)
            2'd0: rsel = rot_row0;
            2'd1: rsel = rot_row1;
            default: rsel = rot_row2;
        endcase
        case (col)
            2'd0: coef = rsel[15:0];
            2'd1: coef = rsel[31:16];
            default: coef = rsel[47:32];
        endcase
        dsel = d_reg[col];
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            d_reg[0] <= 17'(point.px) - 17'($signed(origin_packed[15:0]));
            d_reg[1] <= 17'(point.py) - 17'($signed(origin_packed[31:16]));
            d_reg[2] <= 17'(point.pz) - 17'($signed(origin_packed[47:32]));
            last_reg <= point.last_point;
            acc_reg <= '0;
            mag_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
        end else if (busy_reg) begin
            if (step_reg < 4'd9) begin
                if (col == 2'd2) begin
                    b_reg[row] <= 20'((acc_reg + 36'(coef * dsel)) >>> 14);
                    acc_reg <= '0;
                    row_reg <= row_reg + 2'd1;
                    col_reg <= '0;
                end else begin
                    acc_reg <= acc_reg + 36'(coef * dsel);
                    col_reg <= col_reg + 2'd1;
                end
            end else begin
                sq_reg <= b_reg[step_reg - 4'd9 > 4'd2 ? 2'd2 : 2'(step_reg - 4'd9)];
            end
            if (step_reg >= 4'd10 && step_reg <= 4'd12)
                sqp_reg <= 38'(sq_reg * sq_reg);
            if (step_reg >= 4'd11)
                mag_reg <= mag_reg + 39'(sqp_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == 4'd13) begin
                    busy_reg <= 1'b0;
                    out_vld_reg <= 1'b1;
                end
                step_reg <= step_reg + 4'd1;
            end
        end
    end

    assign bus_out.vld = out_vld_reg;
    assign bus_out.last = last_reg;
    assign bus_out.bx = b_reg[0];
    assign bus_out.by = b_reg[1];
    assign bus_out.mag2 = mag_reg;
endmodule
`default_nettype wire

### hdl/hex_cone_range_sensor_min_core.sv
`default_nettype none
// Six cone range sensors in a ring 60 degrees apart keep the closest axial
// hit of a point cloud. Each point first goes through the shared
// rotation unit (nine matrix products, then three squares on a second
// multiplier), then passes down a chain of six sensor cells, one register
// per cell, where each cell tests the point in its pipeline and updates its
// minimum. The input is not ready again until the last cell has updated.
// A point marked last first yields six results in sensor order, one per
// cycle while the receiver accepts them, and the sensors are then
// cleared. One point is in work at a time.
module hex_cone_range_sensor_min_core (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire hcrs_pkg::point_t       s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output hcrs_pkg::result_t           m_data,
    input  wire logic                   cfg_we,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [47:0]            cfg_data
);
    import hcrs_pkg::*;

    logic [14:0] h_reg, rho_reg;
    logic signed [15:0] mn_reg;
    logic [47:0] r0_reg, r1_reg, r2_reg, org_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg <= 15'd2560;
            rho_reg <= 15'd512;
            mn_reg <= '0;
            r0_reg <= 48'd16384;
            r1_reg <= 48'd1073741824;
            r2_reg <= 48'd70368744177664;
            org_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CONE_LENGTH: h_reg <= cfg_data[14:0];
                REG_CONE_RADIUS: rho_reg <= cfg_data[14:0];
                REG_MIN_RANGE: mn_reg <= cfg_data[15:0];
                REG_ROT_ROW0: r0_reg <= cfg_data;
                REG_ROT_ROW1: r1_reg <= cfg_data;
                REG_ROT_ROW2: r2_reg <= cfg_data;
                REG_ORIGIN: org_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic last_reg, last_next;
    logic [2:0] idx_reg, idx_next;
    logic start, clear;
    cell_bus_t bus [NUM_SENSORS+1];
    logic det [NUM_SENSORS];
    logic signed [15:0] rv [NUM_SENSORS];

    assign start = s_valid && s_ready;

    hcrs_rotate u_rot (
        .aclk, .aresetn, .start, .point(s_data),
        .rot_row0(r0_reg), .rot_row1(r1_reg), .rot_row2(r2_reg),
        .origin_packed(org_reg), .bus_out(bus[0])
    );

    for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_cell
        hcrs_cell #(.SENSOR(g)) u_cell (
            .aclk, .aresetn, .bus_in(bus[g]), .bus_out(bus[g+1]),
            .cone_length(h_reg), .cone_base_radius(rho_reg), .min_range(mn_reg),
            .clear, .detected(det[g]), .range_value(rv[g])
        );
    end

    // Wait long enough for the point to reach the last cell and its update.
    localparam logic [5:0] WAIT = 6'd15 + 6'(NUM_SENSORS) + 6'd5;

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        last_next = last_reg;
        idx_next = idx_reg;
        unique case (state_reg)
            ST_IDLE: if (start) begin
                state_next = ST_CELLS;
                cnt_next = '0;
                last_next = s_data.last_point;
            end
            ST_CELLS: begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == WAIT) begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                    idx_next = '0;
                end
            end
            ST_EMIT: if (m_ready) begin
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'(NUM_SENSORS - 1)) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = (state_reg == ST_EMIT);
        clear = (state_reg == ST_EMIT) && m_ready && (idx_reg == 3'(NUM_SENSORS - 1));
        m_data.sensor_index = idx_reg;
        m_data.detected = det[idx_reg];
        m_data.range_value = rv[idx_reg];
        m_data.last_result = (idx_reg == 3'(NUM_SENSORS - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            last_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            last_reg <= last_next;
            idx_reg <= idx_next;
        end
    end

    logic unused;
    assign unused = ^bus[NUM_SENSORS];
endmodule
`default_nettype wire
